@@ hw/rtl/pdve_pkg.sv @@
package pdve_pkg;

	// Width of the position delta; the difference wraps at this width.
	localparam int unsigned DELTA_WIDTH = 16;
	localparam int unsigned POS_WIDTH = 14;
	localparam int unsigned WEIGHT_WIDTH = 2;
	localparam int unsigned BYTE_WIDTH = 8;

	// A delta at or above this value needs a continuation byte.
	localparam int unsigned CONT_LIMIT = 32;
	localparam int unsigned GROUP_SHIFT = 7;
	localparam int unsigned FINAL_BITS = 5;

	// Byte positions within one item's code.
	localparam logic [1:0] BYTE_FIRST = 2'd0;
	localparam logic [1:0] BYTE_SECOND = 2'd1;
	localparam logic [1:0] BYTE_THIRD = 2'd2;

	// Input item.
	typedef struct packed {
		logic [POS_WIDTH-1:0]    word_position;
		logic [WEIGHT_WIDTH-1:0] weight_class;
		logic                    list_end;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [BYTE_WIDTH-1:0] code_byte;
		logic                  item_done;
	} out_item_t;

	// Item held between the delta stage and the byte emitter.
	typedef struct packed {
		logic                    valid;
		logic [DELTA_WIDTH-1:0]  delta;
		logic [WEIGHT_WIDTH-1:0] weight;
	} stage_t;

endpackage

@@ hw/rtl/pdve_delta.sv @@
module pdve_delta (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pdve_pkg::in_item_t  in_data,
	input  logic                take,
	output pdve_pkg::stage_t    stage
);

	logic                                  valid_s1;
	logic [pdve_pkg::DELTA_WIDTH-1:0]      delta_s1;
	logic [pdve_pkg::WEIGHT_WIDTH-1:0]     weight_s1;
	logic [pdve_pkg::POS_WIDTH-1:0]        prev_q;
	logic                                  accept;
	logic [pdve_pkg::DELTA_WIDTH-1:0]      delta_next;

	// The stage frees up in the same cycle the emitter finishes its last byte.
	assign in_ready = !valid_s1 || take;
	assign accept = in_valid && in_ready;

	// Difference from the previous position, wrapping at the delta width.
	assign delta_next = pdve_pkg::DELTA_WIDTH'(in_data.word_position)
		- pdve_pkg::DELTA_WIDTH'(prev_q);

	// Control state: stage occupancy and the previous position of the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				prev_q <= in_data.list_end ? '0 : in_data.word_position;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Payload of the held item.
	always_ff @(posedge clk) begin
		if (accept) begin
			delta_s1 <= delta_next;
			weight_s1 <= in_data.weight_class;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.delta = delta_s1;
	assign stage.weight = weight_s1;

endmodule

@@ hw/rtl/pdve_emit.sv @@
module pdve_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  pdve_pkg::stage_t    stage,
	output logic                take,
	output logic                out_valid,
	input  logic                out_ready,
	output pdve_pkg::out_item_t out_data
);

	logic                                  out_valid_q;
	pdve_pkg::out_item_t                   out_q;
	logic [1:0]                            idx_q;
	logic [1:0]                            nbytes;
	logic                                  last_byte;
	logic                                  load;
	logic [pdve_pkg::DELTA_WIDTH-1:0]      group1;
	logic [pdve_pkg::DELTA_WIDTH-1:0]      rem;
	pdve_pkg::out_item_t                   next_item;

	// Number of bytes for this delta: one more per 7-bit group while the
	// remaining value is at or above the continuation limit.
	assign group1 = stage.delta >> pdve_pkg::GROUP_SHIFT;

	always_comb begin
		if (stage.delta < pdve_pkg::DELTA_WIDTH'(pdve_pkg::CONT_LIMIT)) begin
			nbytes = 2'd1;
		end else if (group1 < pdve_pkg::DELTA_WIDTH'(pdve_pkg::CONT_LIMIT)) begin
			nbytes = 2'd2;
		end else begin
			nbytes = 2'd3;
		end
	end

	// Remaining delta at the current byte position.
	always_comb begin
		case (idx_q)
			pdve_pkg::BYTE_FIRST: begin
				rem = stage.delta;
			end
			pdve_pkg::BYTE_SECOND: begin
				rem = group1;
			end
			pdve_pkg::BYTE_THIRD: begin
				rem = stage.delta >> (2 * pdve_pkg::GROUP_SHIFT);
			end
			default: begin
				rem = '0;
			end
		endcase
	end

	assign last_byte = (idx_q == 2'(nbytes - 2'd1));

	// Final byte carries weight and low delta bits; others carry 7 bits and
	// the continuation mark.
	always_comb begin
		if (last_byte) begin
			next_item.code_byte = {1'b0, stage.weight, rem[pdve_pkg::FINAL_BITS-1:0]};
			next_item.item_done = 1'b1;
		end else begin
			next_item.code_byte = {1'b1, rem[pdve_pkg::GROUP_SHIFT-1:0]};
			next_item.item_done = 1'b0;
		end
	end

	// The output register takes a new byte when empty or being drained.
	assign load = !out_valid_q || out_ready;
	assign take = load && stage.valid && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= pdve_pkg::BYTE_FIRST;
		end else if (load) begin
			out_valid_q <= stage.valid;
			if (stage.valid) begin
				idx_q <= last_byte ? pdve_pkg::BYTE_FIRST : 2'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && stage.valid) begin
			out_q <= next_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ hw/rtl/position_delta_varint_encoder.sv @@
// Channel | Signals                          | Moves
// --------+----------------------------------+-------------------------------------
// in      | in_valid, in_ready, in_data      | one position item per handshake
// out     | out_valid, out_ready, out_data   | one code byte item per handshake
//
// An accepted item waits in the delta stage while the byte emitter moves one byte per
// cycle, unless the output stalls, into its single output register; an item of one to
// three bytes holds the stage until its last byte is loaded into that register.
// Reset clears the held item, the output register and the previous position.
// A stall on the output holds the current byte; the input stalls only when the
// delta stage is full and its item has not yet sent its last byte.
module position_delta_varint_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pdve_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pdve_pkg::out_item_t out_data
);

	pdve_pkg::stage_t stage;
	logic             take;

	// Delta against the previous position of the list.
	pdve_delta u_delta (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (take),
		.stage    (stage)
	);

	// Varint byte generation.
	pdve_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Finishing an item puts its final byte in the output register.
	a_take_final: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid && out_data.item_done)
		else $error("finished item did not present its final byte");

	// A byte that is not the last of its item carries the continuation bit.
	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.item_done |-> out_data.code_byte[7])
		else $error("continuation byte without continuation bit");

	// An accepted item is held in the delta stage in the next cycle.
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage.valid)
		else $error("accepted item was not held");

endmodule

@@ tb/sv/position_delta_varint_encoder_tb.sv @@
`timescale 1ns / 1ps

module position_delta_varint_encoder_tb;

	// One row of the directed table: the position item and, where it is known
	// in advance, the code bytes that it must produce (n_lit = 0 defers to the predictor).
	typedef struct packed {
		pdve_pkg::in_item_t item;
		logic [1:0]         n_lit;
		logic [0:2][7:0]    lit;
	} dir_row_t;

	localparam int N_DIR = 19;
	localparam int N_RAND = 141;
	localparam int N_TAIL = 30;
	localparam int POS_MAX = (1 << pdve_pkg::POS_WIDTH) - 1;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{'{14'd0,     2'd0, 1'b0}, 2'd1, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd31,    2'd3, 1'b0}, 2'd1, '{8'h7F, 8'h00, 8'h00}},
		'{'{14'd63,    2'd1, 1'b0}, 2'd2, '{8'hA0, 8'h20, 8'h00}},
		'{'{14'd63,    2'd2, 1'b0}, 2'd1, '{8'h40, 8'h00, 8'h00}},
		'{'{14'd16383, 2'd0, 1'b0}, 2'd3, '{8'hC0, 8'hFF, 8'h00}},
		'{'{14'd0,     2'd3, 1'b1}, 2'd3, '{8'h81, 8'h80, 8'h63}},
		'{'{14'd16383, 2'd3, 1'b1}, 2'd3, '{8'hFF, 8'hFF, 8'h60}},
		'{'{14'd100,   2'd0, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd50,    2'd1, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd50,    2'd2, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd4095,  2'd1, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd4096,  2'd2, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd8191,  2'd3, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd8192,  2'd0, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd1,     2'd1, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd16383, 2'd2, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd16383, 2'd1, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd10,    2'd0, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{'{14'd0,     2'd3, 1'b0}, 2'd0, '{8'h00, 8'h00, 8'h00}}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	pdve_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	pdve_pkg::out_item_t out_data;

	// Predictor state and the bytes still owed by the block, oldest first.
	logic [pdve_pkg::POS_WIDTH-1:0] prev_pos;
	pdve_pkg::out_item_t            byte_expect_q[$];

	int  n_err;
	int  n_items;
	int  n_lists;
	int  n_bytes;
	bit  calm;

	position_delta_varint_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Forms the wrapped delta from the previous position and splits it into
	// continuation bytes and one final byte; returns the number of bytes.
	function automatic int encode_position(input pdve_pkg::in_item_t it,
		output pdve_pkg::out_item_t code[3]);
		logic [pdve_pkg::DELTA_WIDTH-1:0] delta;
		int n;
		delta = pdve_pkg::DELTA_WIDTH'(it.word_position)
			- pdve_pkg::DELTA_WIDTH'(prev_pos);
		n = 0;
		while (delta >= pdve_pkg::CONT_LIMIT && n < 2) begin
			code[n].code_byte = {1'b1, delta[pdve_pkg::GROUP_SHIFT-1:0]};
			code[n].item_done = 1'b0;
			n++;
			delta = delta >> pdve_pkg::GROUP_SHIFT;
		end
		code[n].code_byte = {1'b0, it.weight_class, delta[pdve_pkg::FINAL_BITS-1:0]};
		code[n].item_done = 1'b1;
		prev_pos = it.list_end ? '0 : it.word_position;
		return n + 1;
	endfunction

	// Offers one position item, waits for acceptance and queues its code bytes.
	task automatic send_position(input pdve_pkg::in_item_t it, input int n_lit,
		input logic [0:2][7:0] lit);
		pdve_pkg::out_item_t code[3];
		pdve_pkg::out_item_t want;
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n = encode_position(it, code);
		if (n_lit > 0) begin
			for (int i = 0; i < n_lit; i++) begin
				want.code_byte = lit[i];
				want.item_done = (i == n_lit - 1);
				byte_expect_q.push_back(want);
			end
		end else begin
			for (int i = 0; i < n; i++) byte_expect_q.push_back(code[i]);
		end
		n_items++;
		if (it.list_end) n_lists++;
	endtask

	// Output side: ready drops in short bursts except in calm stretches.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare every accepted code byte with the oldest expectation.
	always @(posedge clk) begin
		pdve_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			n_bytes++;
			if (byte_expect_q.size() == 0) begin
				$display("%0t: unexpected code byte: expected none, actual %02h done %0b",
					$time, out_data.code_byte, out_data.item_done);
				n_err++;
			end else begin
				want = byte_expect_q.pop_front();
				if (out_data.code_byte !== want.code_byte) begin
					$display("%0t: code_byte mismatch: expected %02h, actual %02h",
						$time, want.code_byte, out_data.code_byte);
					n_err++;
				end
				if (out_data.item_done !== want.item_done) begin
					$display("%0t: item_done mismatch: expected %0b, actual %0b",
						$time, want.item_done, out_data.item_done);
					n_err++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random lists with some noise.
	initial begin
		pdve_pkg::in_item_t it;
		int n_rand;
		int len;
		int pos;
		int step;
		int sel;
		n_err = 0;
		n_items = 0;
		n_lists = 0;
		n_bytes = 0;
		calm = 1'b0;
		prev_pos = '0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			send_position(DIR_ROWS[r].item, DIR_ROWS[r].n_lit, DIR_ROWS[r].lit);
		end

		n_rand = 0;
		while (n_rand < N_RAND) begin
			calm = ((n_rand / 24) % 3 == 2) || (n_rand >= N_RAND - N_TAIL);
			if ($urandom_range(0, 99) < 15) begin
				// Noise: any position, list end at random.
				it.word_position = pdve_pkg::POS_WIDTH'($urandom_range(0, POS_MAX));
				it.weight_class = pdve_pkg::WEIGHT_WIDTH'($urandom_range(0, 3));
				it.list_end = 1'($urandom_range(0, 1));
				send_position(it, 0, '0);
				n_rand++;
			end else begin
				// Well-formed list of ascending positions.
				len = $urandom_range(1, 8);
				pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POS_MAX)
					: $urandom_range(0, 2000);
				for (int k = 0; k < len && n_rand < N_RAND; k++) begin
					sel = $urandom_range(0, 9);
					if (sel < 6) step = $urandom_range(0, 31);
					else if (sel < 9) step = $urandom_range(32, 4095);
					else step = $urandom_range(4096, POS_MAX);
					if (k > 0) pos = (pos + step > POS_MAX) ? POS_MAX : pos + step;
					it.word_position = pos[pdve_pkg::POS_WIDTH-1:0];
					it.weight_class = pdve_pkg::WEIGHT_WIDTH'($urandom_range(0, 3));
					it.list_end = (k == len - 1);
					send_position(it, 0, '0);
					n_rand++;
				end
			end
		end
		in_valid <= 1'b0;

		while (byte_expect_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Run covered %0d position items (%0d directed) over %0d closed lists,",
			n_items, N_DIR, n_lists);
		$display("and checked %0d code bytes against the predicted encoding.", n_bytes);
		if (n_err == 0) begin
			$display("** position_delta_varint_encoder: PASSED **");
		end else begin
			$display("** position_delta_varint_encoder: FAILED **");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#400000;
		$display("%0t: timeout with %0d code bytes outstanding", $time, byte_expect_q.size());
		$display("** position_delta_varint_encoder: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/pdve_pkg.sv
hw/rtl/pdve_delta.sv
hw/rtl/pdve_emit.sv
hw/rtl/position_delta_varint_encoder.sv
tb/sv/position_delta_varint_encoder_tb.sv
